// ===== rtl/reverse_grain_pre_echo_delay_unit_assert.svh =====
// assertion macros shared by the rtl
`ifndef REVERSE_GRAIN_PRE_ECHO_DELAY_UNIT_ASSERT_SVH
`define REVERSE_GRAIN_PRE_ECHO_DELAY_UNIT_ASSERT_SVH

// same-cycle implication
`define RGPED_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("rgped check failed");

// next-cycle implication
`define RGPED_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("rgped check failed");

`endif

// ===== rtl/rgped_pkg.sv =====
package rgped_pkg;

  localparam int IO_FIELDS = 2;
  localparam int MIN_DELAY = 10;
  localparam int CFG_W     = 21;
  localparam int DELAY_W   = 18;
  localparam int STEP_W    = 21;
  localparam int RATIO_W   = 15;
  localparam int MIX_W     = 16;
  localparam int PHASE_W   = 24;
  localparam int FRAC_W    = 8;
  localparam int WIN_W     = 16;
  localparam int MIX_ONE   = 32768;
  localparam int READS     = 5;

  localparam logic [63:0] PI_Q30 = 64'd3373259426;
  localparam int unsigned DIV_TAB [8] = '{6, 20, 42, 72, 110, 156, 210, 272};

  typedef enum logic [1:0] {
    REG_DELAY,
    REG_STEP,
    REG_RATIO,
    REG_MIX
  } reg_idx_t;

  typedef enum logic [2:0] {
    SL_DRY,
    SL_G1A,
    SL_G1B,
    SL_G2A,
    SL_G2B
  } slot_t;

  typedef struct packed {
    logic  wr_en;
    logic  rd_en;
    slot_t slot;
    logic  zero;
    logic  go;
  } lane_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MULA,
    ST_MULB,
    ST_POS,
    ST_READ,
    ST_CAP,
    ST_GO,
    ST_COMP,
    ST_MERGE
  } state_t;

  // hann entry, sine from an eight term series on the folded angle
  function automatic logic [15:0] hann_entry(int unsigned i, int unsigned bits);
    logic [63:0] n;
    logic [63:0] u;
    logic [63:0] a;
    logic [63:0] a2;
    logic [63:0] t;
    logic [63:0] w;
    longint      s;
    n = 64'd1 << bits;
    u = (64'(i) <= (n >> 1)) ? 64'(i) : n - 64'(i);
    a = (PI_Q30 * u) >> bits;
    a2 = (a * a) >> 30;
    t = a;
    s = longint'(a);
    for (int k = 0; k < 8; k++) begin
      t = ((t * a2) >> 30) / DIV_TAB[k];
      if ((k & 1) == 0) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    if (s > (longint'(1) << 30)) s = longint'(1) << 30;
    w = (64'(s) * 64'(s) + (64'd1 << 44)) >> 45;
    if (w > 64'd32768) w = 64'd32768;
    return w[15:0];
  endfunction

endpackage

// ===== rtl/rgped_hann_rom.sv =====
module rgped_hann_rom #(
  parameter int WTB = 10
) (
  input  logic                         clk,
  input  logic [WTB-1:0]               addr,
  output logic [rgped_pkg::WIN_W-1:0]  q
);

  localparam int WIN = 1 << WTB;

  logic [rgped_pkg::WIN_W-1:0] rom [WIN];
  logic [rgped_pkg::WIN_W-1:0] q_r;

  for (genvar i = 0; i < WIN; i++) begin : g_rom
    assign rom[i] = rgped_pkg::hann_entry(i, WTB);
  end

  always_ff @(posedge clk) begin
    q_r <= rom[addr];
  end

  assign q = q_r;

endmodule

// ===== rtl/rgped_lane.sv =====
module rgped_lane #(
  parameter int DEPTH = 262144,
  parameter int SB    = 24
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  rgped_pkg::lane_ctl_t               ctl,
  input  logic [$clog2(DEPTH)-1:0]           addr,
  input  logic signed [SB-1:0]               wdata,
  input  logic [rgped_pkg::FRAC_W-1:0]       f1,
  input  logic [rgped_pkg::FRAC_W-1:0]       f2,
  input  logic [rgped_pkg::WIN_W-1:0]        w1,
  input  logic [rgped_pkg::WIN_W-1:0]        w2,
  input  logic [rgped_pkg::MIX_W-1:0]        m,
  input  logic [rgped_pkg::MIX_W-1:0]        mc,
  output logic signed [SB-1:0]               res,
  output logic                               done
);

  localparam logic signed [SB+6:0] MAXV = {8'h00, {(SB-1){1'b1}}};
  localparam logic signed [SB+6:0] MINV = {8'hff, {(SB-1){1'b0}}};

  logic signed [SB-1:0] mem [DEPTH];
  logic signed [SB-1:0] q_r;

  logic                 cap_en_r;
  rgped_pkg::slot_t     cap_slot_r;
  logic                 cap_zero_r;
  logic signed [SB-1:0] capval;

  logic signed [SB-1:0] dry_r, s1a_r, s1b_r, s2a_r, s2b_r;
  logic [6:0]           st_r;

  logic [8:0]           f1c, f2c;
  logic signed [SB+9:0] pa1_r, pb1_r, pa2_r, pb2_r;
  logic signed [SB+9:0] sum1, sum2;
  logic signed [SB-1:0] g1_r, g2_r;
  logic signed [SB+16:0] gw1_r, gw2_r, dryw_r;
  logic signed [SB+17:0] s_r;
  logic signed [SB-3:0] s_hi;
  logic signed [SB+14:0] shm_r;
  logic [35:0]          slm_r;
  logic signed [SB+35:0] wet_r;
  logic signed [SB+36:0] acc;
  logic signed [SB+6:0] acc_sh;
  logic signed [SB-1:0] res_r;

  always_ff @(posedge clk) begin
    if (ctl.wr_en) mem[addr] <= wdata;
    if (ctl.rd_en) q_r <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_en_r <= 1'b0;
      st_r     <= '0;
    end else begin
      cap_en_r <= ctl.rd_en;
      st_r     <= {st_r[5:0], ctl.go};
    end
  end

  always_ff @(posedge clk) begin
    cap_slot_r <= ctl.slot;
    cap_zero_r <= ctl.zero;
  end

  assign capval = cap_zero_r ? '0 : q_r;

  always_ff @(posedge clk) begin
    if (cap_en_r) begin
      case (cap_slot_r)
        rgped_pkg::SL_DRY: dry_r <= capval;
        rgped_pkg::SL_G1A: s1a_r <= capval;
        rgped_pkg::SL_G1B: s1b_r <= capval;
        rgped_pkg::SL_G2A: s2a_r <= capval;
        rgped_pkg::SL_G2B: s2b_r <= capval;
        default: ;
      endcase
    end
  end

  assign f1c  = 9'd256 - {1'b0, f1};
  assign f2c  = 9'd256 - {1'b0, f2};
  assign sum1 = pa1_r + pb1_r;
  assign sum2 = pa2_r + pb2_r;
  assign s_hi = s_r[SB+17:20];
  assign acc  = (dryw_r <<< 15) + wet_r;
  assign acc_sh = acc[SB+36:30];

  // interpolate, window, mix, saturate
  always_ff @(posedge clk) begin
    if (ctl.go) begin
      pa1_r <= s1a_r * $signed({1'b0, f1c});
      pb1_r <= s1b_r * $signed({2'b00, f1});
      pa2_r <= s2a_r * $signed({1'b0, f2c});
      pb2_r <= s2b_r * $signed({2'b00, f2});
    end
    if (st_r[0]) begin
      g1_r <= SB'(sum1 >>> 8);
      g2_r <= SB'(sum2 >>> 8);
    end
    if (st_r[1]) begin
      gw1_r  <= g1_r * $signed({1'b0, w1});
      gw2_r  <= g2_r * $signed({1'b0, w2});
      dryw_r <= dry_r * $signed({1'b0, mc});
    end
    if (st_r[2]) s_r <= gw1_r + gw2_r;
    if (st_r[3]) begin
      shm_r <= s_hi * $signed({1'b0, m});
      slm_r <= s_r[19:0] * m;
    end
    if (st_r[4]) wet_r <= (shm_r <<< 20) + $signed({1'b0, slm_r});
    if (st_r[5]) begin
      if (acc_sh > MAXV) res_r <= MAXV[SB-1:0];
      else if (acc_sh < MINV) res_r <= MINV[SB-1:0];
      else res_r <= acc_sh[SB-1:0];
    end
  end

  assign res  = res_r;
  assign done = st_r[6];

endmodule

// ===== rtl/reverse_grain_pre_echo_delay_unit.sv =====
// frames: in_stall holds off a new frame until the last one leaves the merge state,
//   which waits on out_stall; the pace is set by the five reads of each single-port
//   store and the shared grain offset multiplier used once per grain
// reset: control, pointers and config registers return to defaults; stores are not swept,
//   entries beyond the write pointer read as zero until the pointer first wraps
module reverse_grain_pre_echo_delay_unit #(
  parameter int BUFFER_DEPTH      = 262144,
  parameter int CHANNELS          = 2,
  parameter int SAMPLE_BITS       = 24,
  parameter int WINDOW_TABLE_BITS = 10
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_left_in,
  input  logic signed [SAMPLE_BITS-1:0]     in_right_in,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_left_out,
  output logic signed [SAMPLE_BITS-1:0]     out_right_out,
  input  logic                              cfg_we,
  input  logic [1:0]                        cfg_addr,
  input  logic [rgped_pkg::CFG_W-1:0]       cfg_wdata
);

  `include "reverse_grain_pre_echo_delay_unit_assert.svh"

  localparam int AW  = $clog2(BUFFER_DEPTH);
  localparam int DW  = (AW > rgped_pkg::DELAY_W) ? AW : rgped_pkg::DELAY_W;
  localparam int PDW = rgped_pkg::PHASE_W + DW;
  localparam int HW  = PDW - 21;
  localparam int PSW = AW + 8;
  localparam int WTB = WINDOW_TABLE_BITS;

  rgped_pkg::state_t state_r, state_nxt;

  logic [rgped_pkg::DELAY_W-1:0] cfg_delay_r;
  logic [rgped_pkg::STEP_W-1:0]  cfg_step_r;
  logic [rgped_pkg::RATIO_W-1:0] cfg_ratio_r;
  logic [rgped_pkg::MIX_W-1:0]   cfg_mix_r;

  logic                          accept;
  logic [AW-1:0]                 wp_r;
  logic                          wrapped_r;
  logic [rgped_pkg::PHASE_W-1:0] gp_r, gp_nxt, p1_r, phase;
  logic [DW-1:0]                 d_r, d_cl;
  logic [rgped_pkg::MIX_W-1:0]   m_r, mc_r, m_cl;
  logic                          gsel_r;
  logic [2:0]                    rdk_r;
  logic [PDW-1:0]                pd_r;
  logic [35:0]                   lo_r;
  logic [HW+14:0]                hi_r;
  logic [PDW+15:0]               off_sum;
  logic [PSW-1:0]                pos_r [2];
  logic [rgped_pkg::WIN_W-1:0]   w_r [2];
  logic [rgped_pkg::WIN_W-1:0]   rom_q;

  logic [AW-1:0]                 rd_addr, lane_addr;
  rgped_pkg::slot_t              rd_slot;
  rgped_pkg::lane_ctl_t          ctl;
  logic                          out_free, load_out;

  logic signed [SAMPLE_BITS-1:0] lane_wdata [rgped_pkg::IO_FIELDS];
  logic signed [SAMPLE_BITS-1:0] lane_res [rgped_pkg::IO_FIELDS];
  logic [rgped_pkg::IO_FIELDS-1:0] lane_done;

  logic                          out_valid_r;
  logic signed [SAMPLE_BITS-1:0] out_left_r, out_right_r;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != rgped_pkg::ST_IDLE);
  assign out_free = !out_valid_r || !out_stall;
  assign load_out = (state_r == rgped_pkg::ST_MERGE) && out_free;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_delay_r <= rgped_pkg::DELAY_W'(22050);
      cfg_step_r  <= rgped_pkg::STEP_W'(761);
      cfg_ratio_r <= rgped_pkg::RATIO_W'(16384);
      cfg_mix_r   <= rgped_pkg::MIX_W'(16384);
    end else if (cfg_we) begin
      case (cfg_addr)
        rgped_pkg::REG_DELAY: cfg_delay_r <= cfg_wdata[rgped_pkg::DELAY_W-1:0];
        rgped_pkg::REG_STEP:  cfg_step_r  <= cfg_wdata[rgped_pkg::STEP_W-1:0];
        rgped_pkg::REG_RATIO: cfg_ratio_r <= cfg_wdata[rgped_pkg::RATIO_W-1:0];
        rgped_pkg::REG_MIX:   cfg_mix_r   <= cfg_wdata[rgped_pkg::MIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (DW'(cfg_delay_r) < DW'(rgped_pkg::MIN_DELAY)) d_cl = DW'(rgped_pkg::MIN_DELAY);
    else if (DW'(cfg_delay_r) > DW'(BUFFER_DEPTH / 2)) d_cl = DW'(BUFFER_DEPTH / 2);
    else d_cl = DW'(cfg_delay_r);
    if (cfg_mix_r > rgped_pkg::MIX_W'(rgped_pkg::MIX_ONE)) m_cl = rgped_pkg::MIX_W'(rgped_pkg::MIX_ONE);
    else m_cl = cfg_mix_r;
  end

  assign gp_nxt  = gp_r + rgped_pkg::PHASE_W'(cfg_step_r);
  assign phase   = gsel_r ? {~p1_r[rgped_pkg::PHASE_W-1], p1_r[rgped_pkg::PHASE_W-2:0]} : p1_r;
  assign off_sum = (PDW+16)'({hi_r, 21'b0}) + (PDW+16)'(lo_r);

  rgped_hann_rom #(
    .WTB (WTB)
  ) u_rom (
    .clk  (clk),
    .addr (phase[rgped_pkg::PHASE_W-1 -: WTB]),
    .q    (rom_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= rgped_pkg::ST_IDLE;
    else state_r <= state_nxt;
  end

  // next state and store read sequence
  always_comb begin
    state_nxt = state_r;
    rd_addr   = wp_r - AW'(d_r);
    rd_slot   = rgped_pkg::SL_DRY;
    case (rdk_r)
      3'd0: begin
        rd_addr = wp_r - AW'(d_r);
        rd_slot = rgped_pkg::SL_DRY;
      end
      3'd1: begin
        rd_addr = pos_r[0][PSW-1:8];
        rd_slot = rgped_pkg::SL_G1A;
      end
      3'd2: begin
        rd_addr = pos_r[0][PSW-1:8] + AW'(1);
        rd_slot = rgped_pkg::SL_G1B;
      end
      3'd3: begin
        rd_addr = pos_r[1][PSW-1:8];
        rd_slot = rgped_pkg::SL_G2A;
      end
      3'd4: begin
        rd_addr = pos_r[1][PSW-1:8] + AW'(1);
        rd_slot = rgped_pkg::SL_G2B;
      end
      default: ;
    endcase
    case (state_r)
      rgped_pkg::ST_IDLE:  if (accept) state_nxt = rgped_pkg::ST_MULA;
      rgped_pkg::ST_MULA:  state_nxt = rgped_pkg::ST_MULB;
      rgped_pkg::ST_MULB:  state_nxt = rgped_pkg::ST_POS;
      rgped_pkg::ST_POS:   state_nxt = gsel_r ? rgped_pkg::ST_READ : rgped_pkg::ST_MULA;
      rgped_pkg::ST_READ: begin
        if (rdk_r == 3'(rgped_pkg::READS - 1)) state_nxt = rgped_pkg::ST_CAP;
      end
      rgped_pkg::ST_CAP:   state_nxt = rgped_pkg::ST_GO;
      rgped_pkg::ST_GO:    state_nxt = rgped_pkg::ST_COMP;
      rgped_pkg::ST_COMP:  if (|lane_done) state_nxt = rgped_pkg::ST_MERGE;
      rgped_pkg::ST_MERGE: if (out_free) state_nxt = rgped_pkg::ST_IDLE;
      default:             state_nxt = rgped_pkg::ST_IDLE;
    endcase
  end

  assign lane_addr = (state_r == rgped_pkg::ST_READ) ? rd_addr : wp_r;

  always_comb begin
    ctl.wr_en = accept;
    ctl.rd_en = (state_r == rgped_pkg::ST_READ);
    ctl.slot  = rd_slot;
    ctl.zero  = !wrapped_r && (rd_addr > wp_r);
    ctl.go    = (state_r == rgped_pkg::ST_GO);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r      <= '0;
      wrapped_r <= 1'b0;
      gp_r      <= '0;
      gsel_r    <= 1'b0;
      rdk_r     <= '0;
    end else begin
      if (accept) begin
        gp_r   <= gp_nxt;
        gsel_r <= 1'b0;
        rdk_r  <= '0;
      end
      if (state_r == rgped_pkg::ST_POS) gsel_r <= ~gsel_r;
      if (state_r == rgped_pkg::ST_READ) rdk_r <= rdk_r + 3'd1;
      if (load_out) begin
        wp_r <= wp_r + AW'(1);
        if (wp_r == AW'(BUFFER_DEPTH - 1)) wrapped_r <= 1'b1;
      end
    end
  end

  // grain offsets: phase * delay * ratio, split over two multiply stages
  always_ff @(posedge clk) begin
    if (accept) begin
      p1_r <= gp_nxt;
      d_r  <= d_cl;
      m_r  <= m_cl;
      mc_r <= rgped_pkg::MIX_W'(rgped_pkg::MIX_ONE) - m_cl;
    end
    if (state_r == rgped_pkg::ST_MULA) pd_r <= phase * d_r;
    if (state_r == rgped_pkg::ST_MULB) begin
      lo_r <= pd_r[20:0] * cfg_ratio_r;
      hi_r <= pd_r[PDW-1:21] * cfg_ratio_r;
      w_r[gsel_r] <= rom_q;
    end
    if (state_r == rgped_pkg::ST_POS) begin
      pos_r[gsel_r] <= {wp_r, 8'b0} - PSW'(off_sum >> 30);
    end
  end

  assign lane_wdata[0] = in_left_in;
  assign lane_wdata[1] = in_right_in;

  for (genvar c = 0; c < rgped_pkg::IO_FIELDS; c++) begin : g_lane
    if (c < CHANNELS) begin : g_on
      rgped_lane #(
        .DEPTH (BUFFER_DEPTH),
        .SB    (SAMPLE_BITS)
      ) u_lane (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .addr  (lane_addr),
        .wdata (lane_wdata[c]),
        .f1    (pos_r[0][7:0]),
        .f2    (pos_r[1][7:0]),
        .w1    (w_r[0]),
        .w2    (w_r[1]),
        .m     (m_r),
        .mc    (mc_r),
        .res   (lane_res[c]),
        .done  (lane_done[c])
      );
    end else begin : g_off
      assign lane_res[c]  = '0;
      assign lane_done[c] = 1'b0;
    end
  end

  // merge lanes into the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_out) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_left_r  <= lane_res[0];
      out_right_r <= lane_res[1];
    end
  end

  assign out_valid     = out_valid_r;
  assign out_left_out  = out_left_r;
  assign out_right_out = out_right_r;

  `RGPED_ASSERT_NEXT(a_busy_after_accept, accept, in_stall)
  `RGPED_ASSERT_NEXT(a_wp_advance, load_out, wp_r == $past(wp_r) + AW'(1))
  `RGPED_ASSERT_NEXT(a_wrap_sticky, wrapped_r, wrapped_r)
  `RGPED_ASSERT_NOW(a_load_needs_room, load_out, !out_valid_r || !out_stall)

endmodule
